FILE: rtl/bb55_pkg.sv
// bb55_pkg: shared types, constants and the fixed divide-by-25 helper of the
// 5x5 box blur. No dependencies; every other file of the block imports it.
package bb55_pkg;

  // Window geometry
  localparam int RADIUS     = 2;
  localparam int SPAN       = 2 * RADIUS + 1;
  localparam int LINES      = 2 * RADIUS;
  localparam int LINE_AW    = $clog2(LINES);
  localparam int MAX_HEIGHT = 4096;

  // Field widths
  localparam int CH_W    = 8;
  localparam int Q_W     = 4;
  localparam int SUM_W   = 6;
  localparam int PIX_W   = 3 * CH_W;
  localparam int QPIX_W  = 3 * Q_W;
  localparam int WREG_W  = 12;
  localparam int HREG_W  = 13;
  localparam int CFG_DW  = 13;

  // floor(v / 25) for 8-bit v as (v * 41) >> 10
  localparam int RECIP_MUL   = 41;
  localparam int RECIP_SHIFT = 10;
  localparam int PROD_W      = CH_W + 6;

  // Decoupling queue depth
  localparam int QDEPTH = 4;

  // Register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [WREG_W-1:0] width;
    logic [HREG_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic [Q_W-1:0] red;
    logic [Q_W-1:0] green;
    logic [Q_W-1:0] blue;
  } qpix_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } csum_t;

  // One classified word handed from front to back
  typedef struct packed {
    qpix_t              q;
    logic [LINE_AW-1:0] bank;
    logic [LINES-1:0]   rowv;
    logic [LINES-1:0]   colv;
    logic               emit;
    logic               last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [Q_W-1:0] quot25(input logic [CH_W-1:0] v);
    logic [PROD_W-1:0] p;
    p = PROD_W'(v) * PROD_W'(RECIP_MUL);
    return p[RECIP_SHIFT +: Q_W];
  endfunction

endpackage

FILE: rtl/bb55_front.sv
// bb55_front: accepts raster words, tracks the extended column and row and
// classifies each word for the back end. Depends on bb55_pkg.
module bb55_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  bb55_pkg::cfg_t                                cfg_i,
  input  logic                                          fire_i,
  input  logic                                          cmd_i,
  input  logic [bb55_pkg::PIX_W-1:0]                    pix_i,
  output bb55_pkg::item_t                               item_o,
  output logic [$clog2(MAX_WIDTH+bb55_pkg::RADIUS)-1:0] addr_o
);
  import bb55_pkg::*;

  localparam int StoreW = MAX_WIDTH + RADIUS;
  localparam int AW     = $clog2(StoreW);
  localparam int CW     = $clog2(StoreW + 1);

  logic [CW-1:0]     w_eff, x_q, x_d;
  logic [HREG_W-1:0] h_eff, y_q, y_d;
  logic              pix_ok;

  // Clamp register values to the legal range
  always_comb begin
    if (cfg_i.width == '0) begin
      w_eff = CW'(1);
    end else if (int'(cfg_i.width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(cfg_i.width);
    end
    if (cfg_i.height == '0) begin
      h_eff = HREG_W'(1);
    end else if (int'(cfg_i.height) > MAX_HEIGHT) begin
      h_eff = HREG_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_i.height;
    end
  end

  // Extended raster position, wraps at width + radius / height + radius
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (fire_i) begin
      x_d = x_q + CW'(1);
      if ((x_q + CW'(1)) >= (w_eff + CW'(RADIUS))) begin
        x_d = '0;
        y_d = y_q + HREG_W'(1);
        if ((y_q + HREG_W'(1)) >= (h_eff + HREG_W'(RADIUS))) begin
          y_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  // Classify: quotients, row and column masks, output flags
  assign pix_ok = !cmd_i && (x_q < w_eff) && (y_q < h_eff);

  always_comb begin
    item_o.q.blue  = pix_ok ? quot25(pix_i[0*CH_W +: CH_W]) : '0;
    item_o.q.green = pix_ok ? quot25(pix_i[1*CH_W +: CH_W]) : '0;
    item_o.q.red   = pix_ok ? quot25(pix_i[2*CH_W +: CH_W]) : '0;
    item_o.bank    = y_q[LINE_AW-1:0];
    for (int r = 0; r < LINES; r++) begin
      item_o.rowv[r] = y_q >= HREG_W'(LINES - r);
    end
    for (int k = 0; k < LINES; k++) begin
      item_o.colv[k] = x_q >= CW'(LINES - k);
    end
    item_o.emit = (x_q >= CW'(RADIUS)) && (y_q >= HREG_W'(RADIUS));
    item_o.last = (x_q == (w_eff + CW'(RADIUS - 1))) &&
                  (y_q == (h_eff + HREG_W'(RADIUS - 1)));
  end

  assign addr_o = x_q[AW-1:0];

endmodule

FILE: rtl/bb55_fifo.sv
// bb55_fifo: short register queue between front and back of the box blur.
// Depends on bb55_pkg for depth and status type.
module bb55_fifo #(
  parameter int W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [W-1:0]     data_i,
  input  logic             pop_i,
  output logic [W-1:0]     data_o,
  output bb55_pkg::qstat_t stat_o
);
  import bb55_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int NW = $clog2(QDEPTH + 1);

  logic [W-1:0]  mem_q [QDEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] cnt_q, cnt_d;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + NW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = cnt_q == NW'(QDEPTH);
  assign stat_o.empty = cnt_q == '0;

endmodule

FILE: rtl/bb55_back.sv
// bb55_back: line store, window column sums and output register of the box
// blur. Depends on bb55_pkg.
module bb55_back #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  output logic                                          pop_o,
  input  bb55_pkg::item_t                               item_i,
  input  logic [$clog2(MAX_WIDTH+bb55_pkg::RADIUS)-1:0] addr_i,
  output logic                                          m_valid_o,
  input  logic                                          m_ready_i,
  output logic [bb55_pkg::PIX_W-1:0]                    m_data_o,
  output logic                                          m_last_o
);
  import bb55_pkg::*;

  localparam int StoreW = MAX_WIDTH + RADIUS;

  logic                a_fire, b_fire;
  logic                s1_valid_q;
  item_t               s1_q;
  logic [QPIX_W-1:0]   rd [LINES];
  csum_t               win_q [LINES];
  csum_t               col;
  logic [CH_W-1:0]     tot_r, tot_g, tot_b;
  logic                out_valid_q;
  logic [PIX_W-1:0]    out_data_q;
  logic                out_last_q;

  // Stage advance
  assign b_fire = s1_valid_q && (!out_valid_q || m_ready_i);
  assign a_fire = valid_i && (!s1_valid_q || b_fire);
  assign pop_o  = a_fire;

  // Line store: one bank per buffered row, read before write
  for (genvar i = 0; i < LINES; i++) begin : g_bank
    logic [QPIX_W-1:0] mem [StoreW];
    logic [QPIX_W-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (a_fire) begin
        rd_q <= mem[addr_i];
        if (item_i.bank == LINE_AW'(i)) begin
          mem[addr_i] <= item_i.q;
        end
      end
    end
    assign rd[i] = rd_q;
  end

  // Stage 1 word
  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      s1_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (a_fire) begin
      s1_valid_q <= 1'b1;
    end else if (b_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // New column sum: buffered rows (masked above the frame top) plus current
  always_comb begin
    qpix_t              rq;
    logic [LINE_AW-1:0] idx;
    col.red   = SUM_W'(s1_q.q.red);
    col.green = SUM_W'(s1_q.q.green);
    col.blue  = SUM_W'(s1_q.q.blue);
    for (int r = 0; r < LINES; r++) begin
      idx = s1_q.bank + LINE_AW'(r);
      rq  = rd[idx];
      if (s1_q.rowv[r]) begin
        col.red   = col.red   + SUM_W'(rq.red);
        col.green = col.green + SUM_W'(rq.green);
        col.blue  = col.blue  + SUM_W'(rq.blue);
      end
    end
  end

  // Window total: older columns masked left of the frame
  always_comb begin
    tot_r = CH_W'(col.red);
    tot_g = CH_W'(col.green);
    tot_b = CH_W'(col.blue);
    for (int k = 0; k < LINES; k++) begin
      if (s1_q.colv[k]) begin
        tot_r = tot_r + CH_W'(win_q[k].red);
        tot_g = tot_g + CH_W'(win_q[k].green);
        tot_b = tot_b + CH_W'(win_q[k].blue);
      end
    end
  end

  // Column sum shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LINES; k++) begin
        win_q[k] <= '0;
      end
    end else if (b_fire) begin
      for (int k = 0; k < LINES - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[LINES-1] <= col;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (b_fire && s1_q.emit) begin
      out_data_q <= {tot_r, tot_g, tot_b};
      out_last_q <= s1_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_fire && s1_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;

endmodule

FILE: rtl/box_blur_5x5_rgb.sv
// box_blur_5x5_rgb: top level of the streaming 5x5 RGB box blur: register
// file, front end, queue and back end. Depends on bb55_pkg and all bb55_*.
//
//   channel   | dir | handshake              | payload
//   ----------+-----+------------------------+--------------------------------
//   s_axis    | in  | s_axis_tvalid/tready   | tdata blue,green,red; tuser cmd
//   m_axis    | out | m_axis_tvalid/tready   | tdata blue,green,red; tlast
//   cfg       | in  | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One word per cycle sustained in both directions while m_axis_tready is high.
// A word is classified by the front, then registered in the queue, in stage 1
// with the single-port line store read, then summed into the output register.
// Reset clears counters, window and queue; the line store is not cleared,
// rows above the frame top are masked by row position instead.
// Output stalls back up through a 4-word queue before s_axis_tready drops.
module box_blur_5x5_rgb #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [bb55_pkg::CFG_DW-1:0]   cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bb55_pkg::PIX_W-1:0]    s_axis_tdata,   // in_blue, in_green, in_red
  input  logic                          s_axis_tuser,   // cmd
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bb55_pkg::PIX_W-1:0]    m_axis_tdata,   // out_blue, out_green, out_red
  output logic                          m_axis_tlast    // frame_last
);
  import bb55_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH + RADIUS);
  localparam int QW = AW + $bits(item_t);

  cfg_t          cfg_q;
  logic          s_fire;
  item_t         f_item, b_item;
  logic [AW-1:0] f_addr, b_addr;
  logic [QW-1:0] q_out;
  qstat_t        q_stat;
  logic          pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= WREG_W'(640);
      cfg_q.height <= HREG_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  cfg_q.width  <= cfg_wdata_i[WREG_W-1:0];
        REG_HEIGHT: cfg_q.height <= cfg_wdata_i[HREG_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_stat.full;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  bb55_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .fire_i (s_fire),
    .cmd_i  (s_axis_tuser),
    .pix_i  (s_axis_tdata),
    .item_o (f_item),
    .addr_o (f_addr)
  );

  bb55_fifo #(
    .W(QW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s_fire),
    .data_i ({f_addr, f_item}),
    .pop_i  (pop),
    .data_o (q_out),
    .stat_o (q_stat)
  );

  assign b_addr = q_out[QW-1 -: AW];
  assign b_item = item_t'(q_out[$bits(item_t)-1:0]);

  bb55_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (!q_stat.empty),
    .pop_o     (pop),
    .item_i    (b_item),
    .addr_i    (b_addr),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

  // Checks
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] <= 8'd250) && (m_axis_tdata[15:8] <= 8'd250) &&
                      (m_axis_tdata[23:16] <= 8'd250))
    else $error("blurred channel above 250");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !pop) |=> !q_stat.empty)
    else $error("accepted word lost from queue");

endmodule

FILE: test/box_blur_5x5_rgb_test.sv
// Self-checking bench for box_blur_5x5_rgb: streams padded frames in, predicts
// every blurred word in-bench and compares the output stream word by word.
// Depends on bb55_pkg (port widths, register indexes) and the block's RTL.
`timescale 1ns / 1ps

module box_blur_5x5_rgb_test;

  localparam logic CMD_PIXEL  = 1'b0;
  localparam logic CMD_PAD    = 1'b1;
  localparam int   BORDER     = 2;              // pad columns after each row / pad rows after each frame
  localparam int   WIN        = 2 * BORDER + 1;
  localparam int   BANKS      = 2 * BORDER;
  localparam int   MAX_COLS   = 2048;
  localparam int   MAX_ROWS   = 4096;
  localparam int   STORE_COLS = MAX_COLS + BORDER;
  localparam int   SETTLE     = 20;             // extra wait in cycles after the last predicted word
  localparam int   SINK_HOLD  = 160;            // long output stall, in cycles
  localparam int   RAND_WORDS = 300;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } blur_word_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic                          cfg_idx_i;
  logic [bb55_pkg::CFG_DW-1:0]   cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [bb55_pkg::PIX_W-1:0]    s_axis_tdata;   // in_blue, in_green, in_red
  logic                          s_axis_tuser;   // cmd
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [bb55_pkg::PIX_W-1:0]    m_axis_tdata;   // out_blue, out_green, out_red
  logic                          m_axis_tlast;   // frame_last

  box_blur_5x5_rgb dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Blur predictor state: quotient line buffer, 5x5 window, raster position
  bit [3:0]    line_q [BANKS][STORE_COLS][3];
  bit [3:0]    win_q  [WIN][WIN][3];
  int unsigned col_pos  = 0;
  int unsigned row_pos  = 0;
  bit [11:0]   width_reg  = 12'd640;
  bit [12:0]   height_reg = 13'd480;
  blur_word_t  blurred_q [$];

  // Bookkeeping
  int err_count    = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int frames_done  = 0;
  bit idle_on      = 1'b0;
  int hold_asked   = 0;
  int hold_done    = 0;
  int hold_left    = 0;
  int rx_gap       = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned frame_w();
    return clamp_dim(width_reg, MAX_COLS);
  endfunction

  function automatic int unsigned frame_h();
    return clamp_dim(height_reg, MAX_ROWS);
  endfunction

  // Random channel value, extremes favored
  function automatic logic [7:0] rand_chan();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Advance the blur predictor by one accepted word; queue the blurred word if any
  task automatic blur_predict(input logic cmd, input logic [23:0] pix);
    int unsigned w, h, x, y, xs;
    int unsigned acc [3];
    bit [3:0]    q [3];
    bit [3:0]    column [WIN][3];
    blur_word_t  e;
    int          r, k, c;
    w  = frame_w();
    h  = frame_h();
    x  = col_pos;
    y  = row_pos;
    xs = (x < STORE_COLS) ? x : STORE_COLS - 1;
    // only an in-frame word flagged as pixel contributes
    for (c = 0; c < 3; c++)
      q[c] = (cmd == CMD_PIXEL && x < w && y < h) ? 4'(pix[8*c +: 8] / 25) : 4'd0;
    // new window column: four buffered rows above, the new word at the bottom
    for (r = 0; r < WIN; r++) begin
      for (c = 0; c < 3; c++) begin
        if (r == BANKS) column[r][c] = q[c];
        else if (y + r < BANKS) column[r][c] = 4'd0;
        else column[r][c] = line_q[(y + r - BANKS) % BANKS][xs][c];
      end
    end
    for (c = 0; c < 3; c++) line_q[y % BANKS][xs][c] = q[c];
    for (r = 0; r < WIN; r++) begin
      for (k = 0; k < WIN - 1; k++) win_q[r][k] = win_q[r][k + 1];
      win_q[r][WIN - 1] = column[r];
    end
    // emit once two rows and two columns are in; columns left of the frame drop out
    if (x >= BORDER && y >= BORDER) begin
      acc = '{0, 0, 0};
      for (r = 0; r < WIN; r++)
        for (k = 0; k < WIN; k++)
          if (x + k >= BANKS)
            for (c = 0; c < 3; c++) acc[c] += win_q[r][k][c];
      e.blue  = 8'(acc[0]);
      e.green = 8'(acc[1]);
      e.red   = 8'(acc[2]);
      e.last  = (x == w + BORDER - 1 && y == h + BORDER - 1);
      blurred_q.push_back(e);
    end
    // raster counters wrap at the padded size, even if it shrank mid-frame
    col_pos = x + 1;
    if (col_pos >= w + BORDER) begin
      col_pos = 0;
      row_pos = y + 1;
      if (row_pos >= h + BORDER) row_pos = 0;
      if (row_pos == 0) frames_done++;
    end
  endtask

  task automatic note_mismatch(input string what);
    err_count++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  // Compare one output word against the oldest prediction
  task automatic check_blurred();
    blur_word_t e;
    if (blurred_q.size() == 0) begin
      note_mismatch($sformatf("unexpected word %h last %b", m_axis_tdata, m_axis_tlast));
      return;
    end
    e = blurred_q.pop_front();
    results_seen++;
    if (m_axis_tdata[7:0] !== e.blue)
      note_mismatch($sformatf("blue %0d, want %0d", m_axis_tdata[7:0], e.blue));
    if (m_axis_tdata[15:8] !== e.green)
      note_mismatch($sformatf("green %0d, want %0d", m_axis_tdata[15:8], e.green));
    if (m_axis_tdata[23:16] !== e.red)
      note_mismatch($sformatf("red %0d, want %0d", m_axis_tdata[23:16], e.red));
    if (m_axis_tlast !== e.last)
      note_mismatch($sformatf("frame_last %b, want %b", m_axis_tlast, e.last));
  endtask

  // Offer one word, optionally after a gap; predict it once accepted
  task automatic send_word(input logic cmd, input logic [23:0] pix);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    blur_predict(cmd, pix);
    words_sent++;
  endtask

  // Stream padded raster words until the frame wraps or max_words went out;
  // noise_pct flips the pad/pixel flag on that share of words
  task automatic send_span(input int max_words, input int noise_pct);
    int          n;
    logic        cmd;
    logic [23:0] pix;
    n = 0;
    do begin
      cmd = (col_pos < frame_w() && row_pos < frame_h()) ? CMD_PIXEL : CMD_PAD;
      if ($urandom_range(0, 99) < noise_pct) cmd = ~cmd;
      pix = {rand_chan(), rand_chan(), rand_chan()};
      send_word(cmd, pix);
      n++;
    end while (n < max_words && (col_pos != 0 || row_pos != 0));
  endtask

  // Stop sending and let every predicted word come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write width then height; only called with the block idle
  task automatic set_frame_size(input logic [11:0] wv, input logic [12:0] hv);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= bb55_pkg::REG_WIDTH;
    cfg_wdata_i <= bb55_pkg::CFG_DW'(wv);
    @(posedge clk_i);
    width_reg    = wv;
    cfg_idx_i   <= bb55_pkg::REG_HEIGHT;
    cfg_wdata_i <= hv;
    @(posedge clk_i);
    height_reg = hv;
    cfg_we_i  <= 1'b0;
  endtask

  // Zero sizes clamp to 1x1; pad flag and frame position disagree both ways
  task automatic test_tiny_frames();
    idle_on = 1'b0;
    set_frame_size(12'd0, 13'd0);
    send_word(CMD_PIXEL, 24'hFFFFFF);
    repeat (8) send_word(CMD_PIXEL, 24'hFFFFFF);   // outside frame: ignored
    wait_drained();
    set_frame_size(12'd2, 13'd1);
    send_word(CMD_PAD, 24'hFFFFFF);                 // inside frame: adds zero
    send_word(CMD_PIXEL, {8'd200, 8'd25, 8'd24});
    repeat (10) send_word(CMD_PAD, 24'h000000);
    wait_drained();
  endtask

  // Shrink width, then height, in the middle of a frame
  task automatic test_size_cut();
    idle_on = 1'b1;
    set_frame_size(12'd12, 13'd6);
    send_span(3 * (12 + BORDER) + 10, 0);
    wait_drained();
    set_frame_size(12'd3, 13'd6);
    send_span(1 << 20, 0);
    wait_drained();
    set_frame_size(12'd10, 13'd8);
    send_span(5 * (10 + BORDER) + 4, 0);
    wait_drained();
    set_frame_size(12'd10, 13'd3);
    send_span(1 << 20, 0);
    wait_drained();
  endtask

  // Mostly clean frames of small random size, some with corrupted pad flags
  task automatic test_random_frames();
    int        start;
    bit [11:0] wv;
    bit [12:0] hv;
    start = words_sent;
    while (words_sent - start < RAND_WORDS) begin
      wv = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(13, 30))
                                       : 12'($urandom_range(1, 12));
      hv = 13'($urandom_range(1, 8));
      set_frame_size(wv, hv);
      idle_on = ($urandom_range(0, 3) != 0);
      send_span(1 << 20, ($urandom_range(0, 3) == 0) ? 10 : 0);
      wait_drained();
    end
  endtask

  // Long output stall while input keeps coming, so the input side backs up
  task automatic test_output_stall();
    idle_on = 1'b0;
    set_frame_size(12'd16, 13'd6);
    hold_asked <= hold_asked + 1;
    send_span(1 << 20, 0);
    wait_drained();
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Output side: check each accepted word, then pick next cycle's ready
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_blurred();
      if (hold_asked != hold_done) begin
        hold_done++;
        hold_left = SINK_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(1, 6) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Sequence
  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= bb55_pkg::REG_WIDTH;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_PAD;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_tiny_frames();
    test_size_cut();
    test_random_frames();
    test_output_stall();
    wait_drained();

    $display("blur run: %0d frames, %0d input words, %0d blurred words checked",
             frames_done, words_sent, results_seen);
    $display("covered size clamps, mid-frame size cuts, pad flag mismatches, a %0d-cycle stall",
             SINK_HOLD);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
